// File: hdl/slrp_pkg.sv
// Shared types, constants and codes of the sampled low-rank product unit.
package slrp_pkg;

  // Store geometry.
  localparam int MAX_ROWS   = 256;
  localparam int MAX_RANK   = 32;
  localparam int ROW_W      = 8;
  localparam int COL_W      = 5;
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_RANK;

  // Field and register widths.
  localparam int VAL_W    = 32;
  localparam int ACC_W    = 64;
  localparam int RANK_W   = 6;
  localparam int ROWCNT_W = 9;
  localparam int CFG_W    = 9;
  localparam int CIDX_W   = 2;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_LOAD_U = 2'd0,
    OP_LOAD_V = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  // Configuration register indexes.
  typedef enum logic [CIDX_W-1:0] {
    CFG_RANK   = 2'd0,
    CFG_U_ROWS = 2'd1,
    CFG_V_ROWS = 2'd2,
    CFG_SPARE  = 2'd3
  } cfg_index_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_u;
    logic load_v;
    logic start;
    logic issue;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;      // query needs no reads: row out of range or empty rank
    logic last;      // current read is the final rank column
    logic out_free;  // output register can take a new result this cycle
  } dp_status_t;

endpackage

// File: hdl/sampled_low_rank_product_unit.sv
// Top level of the sampled low-rank product unit.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  opcode, load_row, load_col, load_value,
//                                             query_u_row, query_v_row
//   output    out        out_valid/out_stall  dot_product, index_error, saturated
//   config    in         cfg_we               cfg_index, cfg_data
//
// A load transaction writes one element of a factor store.
// A query holds the input after acceptance (rank capped at 32) through one read of both
// factor stores per rank column, then while the read and multiply registers empty,
// then until the sum can move into the output register.
// A query with a row out of range or an empty rank skips the reads and only waits to load the output register.
// The factor stores are not cleared by reset; the configuration takes its defaults.
// A waiting result holds while out_stall is high; input is still taken meanwhile unless a query is in progress.
module sampled_low_rank_product_unit
  import slrp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CIDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              opcode,
  input  logic [ROW_W-1:0]        load_row,
  input  logic [COL_W-1:0]        load_col,
  input  logic signed [VAL_W-1:0] load_value,
  input  logic [ROW_W-1:0]        query_u_row,
  input  logic [ROW_W-1:0]        query_v_row,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [ACC_W-1:0] dot_product,
  output logic                    index_error,
  output logic                    saturated
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer.
  slrp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Stores and arithmetic.
  slrp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .load_row    (load_row),
    .load_col    (load_col),
    .load_value  (load_value),
    .query_u_row (query_u_row),
    .query_v_row (query_v_row),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .dot_product (dot_product),
    .index_error (index_error),
    .saturated   (saturated)
  );

endmodule

// File: hdl/slrp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slrp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/slrp_ctrl.sv
// Controller state machine of the sampled low-rank product unit.
module slrp_ctrl
  import slrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] opcode,
  output logic       in_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   drain_cnt, drain_cnt_next;
  logic   accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_next     = state;
    drain_cnt_next = drain_cnt;
    cmd            = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_u = (opcode == OP_LOAD_U);
          cmd.load_v = (opcode == OP_LOAD_V);
          if (opcode == OP_QUERY) begin
            cmd.start  = 1'b1;
            state_next = status.skip ? ST_FINISH : ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (status.last) begin
          state_next     = ST_DRAIN;
          drain_cnt_next = 1'b0;
        end
      end
      ST_DRAIN: begin
        // Wait here while the read data and product registers empty.
        drain_cnt_next = 1'b1;
        if (drain_cnt) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      drain_cnt <= 1'b0;
    end else begin
      state     <= state_next;
      drain_cnt <= drain_cnt_next;
    end
  end

endmodule

// File: hdl/slrp_dp.sv
// Datapath: configuration registers, factor stores, multiply-accumulate, output register.
module slrp_dp
  import slrp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CIDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic [ROW_W-1:0]        load_row,
  input  logic [COL_W-1:0]        load_col,
  input  logic signed [VAL_W-1:0] load_value,
  input  logic [ROW_W-1:0]        query_u_row,
  input  logic [ROW_W-1:0]        query_v_row,
  input  ctrl_cmd_t               cmd,
  output dp_status_t              status,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [ACC_W-1:0] dot_product,
  output logic                    index_error,
  output logic                    saturated
);

  logic [RANK_W-1:0]       rank_in_use;
  logic [ROWCNT_W-1:0]     u_row_count;
  logic [ROWCNT_W-1:0]     v_row_count;
  logic [RANK_W-1:0]       rank_eff;
  logic [ROWCNT_W-1:0]     u_cap, v_cap;
  logic                    row_err;
  logic [RANK_W-1:0]       rank_reg;
  logic [ROW_W-1:0]        u_row, v_row;
  logic                    err_reg;
  logic [COL_W-1:0]        col;
  logic                    rd_v, mul_v;
  logic [VAL_W-1:0]        u_data, v_data;
  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic                    sat;
  logic signed [ACC_W:0]   sum;
  logic [ADDR_W-1:0]       waddr;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rank_in_use <= RANK_W'(MAX_RANK);
      u_row_count <= ROWCNT_W'(MAX_ROWS);
      v_row_count <= ROWCNT_W'(MAX_ROWS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RANK:   rank_in_use <= cfg_data[RANK_W-1:0];
        CFG_U_ROWS: u_row_count <= cfg_data;
        CFG_V_ROWS: v_row_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capped rank and row counts, and the range check of an incoming query.
  assign rank_eff = (rank_in_use > RANK_W'(MAX_RANK)) ? RANK_W'(MAX_RANK) : rank_in_use;
  assign u_cap = (u_row_count > ROWCNT_W'(MAX_ROWS)) ? ROWCNT_W'(MAX_ROWS) : u_row_count;
  assign v_cap = (v_row_count > ROWCNT_W'(MAX_ROWS)) ? ROWCNT_W'(MAX_ROWS) : v_row_count;
  assign row_err = ({1'b0, query_u_row} >= u_cap) || ({1'b0, query_v_row} >= v_cap);

  assign status.skip     = row_err || (rank_eff == '0);
  assign status.last     = (RANK_W'(col) == rank_reg - RANK_W'(1));
  assign status.out_free = !out_valid || !out_stall;

  // Query registers and the column counter.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rank_reg <= rank_eff;
      u_row    <= query_u_row;
      v_row    <= query_v_row;
      err_reg  <= row_err;
    end
    if (cmd.start) begin
      col <= '0;
    end else if (cmd.issue) begin
      col <= col + COL_W'(1);
    end
  end

  // Factor stores.
  assign waddr = {load_row, load_col};

  slrp_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (cmd.load_u),
    .waddr (waddr),
    .wdata (load_value),
    .re    (cmd.issue),
    .raddr ({u_row, col}),
    .rdata (u_data)
  );

  slrp_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) v_store (
    .clk   (clk),
    .we    (cmd.load_v),
    .waddr (waddr),
    .wdata (load_value),
    .re    (cmd.issue),
    .raddr ({v_row, col}),
    .rdata (v_data)
  );

  // Pipeline valid bits for the read and multiply stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      mul_v <= 1'b0;
    end else begin
      rd_v  <= cmd.issue;
      mul_v <= rd_v;
    end
  end

  // Exact Q32.32 product of two Q16.16 elements.
  always_ff @(posedge clk) begin
    if (rd_v) begin
      prod <= ACC_W'($signed(u_data) * $signed(v_data));
    end
  end

  // Saturating accumulation: clip at each step and carry on from the clipped value.
  assign sum = {acc[ACC_W-1], acc} + {prod[ACC_W-1], prod};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc <= '0;
      sat <= 1'b0;
    end else if (mul_v) begin
      if (sum[ACC_W] != sum[ACC_W-1]) begin
        acc <= sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        sat <= 1'b1;
      end else begin
        acc <= sum[ACC_W-1:0];
      end
    end
  end

  // Output register; a waiting transaction holds until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      dot_product <= err_reg ? '0 : acc;
      index_error <= err_reg;
      saturated   <= err_reg ? 1'b0 : sat;
    end
  end

endmodule

// File: hdl/slrp_checker.sv
// Port-level checks of the sampled low-rank product unit, bound to the top level.
module slrp_checker
  import slrp_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    cfg_we,
  input logic [CIDX_W-1:0]       cfg_index,
  input logic [CFG_W-1:0]        cfg_data,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [1:0]              opcode,
  input logic [ROW_W-1:0]        load_row,
  input logic [COL_W-1:0]        load_col,
  input logic signed [VAL_W-1:0] load_value,
  input logic [ROW_W-1:0]        query_u_row,
  input logic [ROW_W-1:0]        query_v_row,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [ACC_W-1:0] dot_product,
  input logic                    index_error,
  input logic                    saturated
);

  // A stalled result transaction stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction withdrawn while stalled");

  // A stalled result does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(dot_product) && $stable(index_error)
                               && $stable(saturated))
    else $error("stalled result changed");

  // An index error carries a zero sum and no saturation.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> (dot_product == '0) && !saturated)
    else $error("index error with non-zero result");

  // An accepted query occupies the unit in the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (opcode == OP_QUERY) |=> in_stall)
    else $error("input taken during a query");

  // No result is offered straight after reset.
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result offered after reset");

endmodule

bind sampled_low_rank_product_unit slrp_checker u_slrp_checker (.*);

// File: tb/sv/sampled_low_rank_product_unit_tb.sv
// Self-checking testbench for the sampled low-rank product unit.
`timescale 1ns / 1ps

module sampled_low_rank_product_unit_tb;
  import slrp_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES = 9;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [ACC_W-1:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] SUM_MIN = 64'sh8000_0000_0000_0000;

  // One result of a query.
  typedef struct packed {
    logic signed [ACC_W-1:0] dot;
    logic                    err;
    logic                    sat;
  } dot_result_t;

  // One input transaction, with an optional hand-written expectation.
  typedef struct packed {
    opcode_t                 op;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic [ROW_W-1:0]        qu;
    logic [ROW_W-1:0]        qv;
    logic                    known;
    dot_result_t             res;
  } op_item_t;

  // Configuration of each random phase: rank, U rows, V rows, input transactions.
  int phase_rank  [PHASES] = '{32, 1, 5, 0, 40, 63, 17, 3, 32};
  int phase_u     [PHASES] = '{256, 16, 8, 256, 511, 1, 12, 256, 256};
  int phase_v     [PHASES] = '{256, 16, 300, 256, 0, 256, 9, 256, 256};
  int phase_items [PHASES] = '{150, 80, 80, 50, 40, 80, 100, 100, 70};

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CIDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              opcode = '0;
  logic [ROW_W-1:0]        load_row = '0;
  logic [COL_W-1:0]        load_col = '0;
  logic signed [VAL_W-1:0] load_value = '0;
  logic [ROW_W-1:0]        query_u_row = '0;
  logic [ROW_W-1:0]        query_v_row = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [ACC_W-1:0] dot_product;
  logic                    index_error;
  logic                    saturated;

  // Predictor state: factor images and register copies.
  logic signed [VAL_W-1:0] u_image [STORE_DEPTH];
  logic signed [VAL_W-1:0] v_image [STORE_DEPTH];
  logic [RANK_W-1:0]       rank_cfg = 6'd32;
  logic [ROWCNT_W-1:0]     u_rows_cfg = 9'd256;
  logic [ROWCNT_W-1:0]     v_rows_cfg = 9'd256;

  // Columns written so far in each row, used to keep queries on written data.
  logic [MAX_RANK-1:0]     u_filled [MAX_ROWS];
  logic [MAX_RANK-1:0]     v_filled [MAX_ROWS];

  dot_result_t             pending_dots [$];
  logic                    item_known = 1'b0;
  dot_result_t             item_known_res = '0;
  bit                      idle_on = 1'b1;
  int                      mismatches = 0;
  int                      quiet_cycles = 0;

  sampled_low_rank_product_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .load_row    (load_row),
    .load_col    (load_col),
    .load_value  (load_value),
    .query_u_row (query_u_row),
    .query_v_row (query_v_row),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .dot_product (dot_product),
    .index_error (index_error),
    .saturated   (saturated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Effective rank and row limits, with the registers capped at the store size.
  function automatic int rank_limit();
    return (rank_cfg > MAX_RANK) ? MAX_RANK : int'(rank_cfg);
  endfunction

  function automatic int row_limit(input logic [ROWCNT_W-1:0] count);
    return (count > MAX_ROWS) ? MAX_ROWS : int'(count);
  endfunction

  function automatic logic [MAX_RANK-1:0] need_mask();
    int n;
    n = rank_limit();
    return (n == MAX_RANK) ? '1 : ((32'd1 << n) - 32'd1);
  endfunction

  // Saturating dot product of one U row with one V row.
  function automatic dot_result_t predict_entry(input logic [ROW_W-1:0] ur,
                                                input logic [ROW_W-1:0] vr);
    dot_result_t             r;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
    logic signed [ACC_W-1:0] prod;
    logic [COL_W-1:0]        col;
    r = '0;
    acc = '0;
    if (ur >= row_limit(u_rows_cfg) || vr >= row_limit(v_rows_cfg)) begin
      r.err = 1'b1;
      return r;
    end
    for (int k = 0; k < rank_limit(); k++) begin
      col = k[COL_W-1:0];
      a = u_image[{ur, col}];
      b = v_image[{vr, col}];
      prod = a * b;
      if (prod > 0 && acc > SUM_MAX - prod) begin
        acc = SUM_MAX;
        r.sat = 1'b1;
      end else if (prod < 0 && acc < SUM_MIN - prod) begin
        acc = SUM_MIN;
        r.sat = 1'b1;
      end else begin
        acc = acc + prod;
      end
    end
    r.dot = acc;
    return r;
  endfunction

  // A query may be sent if it reports an index error or reads only written columns.
  function automatic bit query_ok(input logic [ROW_W-1:0] ur, input logic [ROW_W-1:0] vr);
    logic [MAX_RANK-1:0] need;
    need = need_mask();
    if (ur >= row_limit(u_rows_cfg) || vr >= row_limit(v_rows_cfg))
      return 1'b1;
    return ((u_filled[ur] & need) == need) && ((v_filled[vr] & need) == need);
  endfunction

  function automatic op_item_t load_item(input opcode_t op, input logic [ROW_W-1:0] row,
                                         input logic [COL_W-1:0] col,
                                         input logic signed [VAL_W-1:0] value);
    op_item_t t;
    t = '0;
    t.op = op;
    t.row = row;
    t.col = col;
    t.value = value;
    return t;
  endfunction

  function automatic op_item_t query_item(input logic [ROW_W-1:0] ur,
                                          input logic [ROW_W-1:0] vr);
    op_item_t t;
    t = '0;
    t.op = OP_QUERY;
    t.qu = ur;
    t.qv = vr;
    return t;
  endfunction

  function automatic op_item_t known_query(input logic [ROW_W-1:0] ur,
                                           input logic [ROW_W-1:0] vr,
                                           input logic signed [ACC_W-1:0] dot,
                                           input logic err, input logic sat);
    op_item_t t;
    t = query_item(ur, vr);
    t.known = 1'b1;
    t.res.dot = dot;
    t.res.err = err;
    t.res.sat = sat;
    return t;
  endfunction

  // Element values: whole rows at one extreme, or a mix of extremes, units and noise.
  function automatic logic signed [VAL_W-1:0] rand_q16(input int style);
    if (style == 0)
      return VAL_MAX;
    if (style == 1)
      return VAL_MIN;
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return 32'sh0001_0000;
      4: return 32'shFFFF_0000;
      5, 6: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // Present one input transaction and hold it until it is accepted.
  task automatic drive_txn(input op_item_t t);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= t.op;
    load_row <= t.row;
    load_col <= t.col;
    load_value <= t.value;
    query_u_row <= t.qu;
    query_v_row <= t.qv;
    item_known = t.known;
    item_known_res = t.res;
    if (t.op == OP_LOAD_U)
      u_filled[t.row][t.col] = 1'b1;
    else if (t.op == OP_LOAD_V)
      v_filled[t.row][t.col] = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Let every expected result arrive, then allow the block to go quiet.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_dots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes on consecutive cycles; the block is idle here.
  task automatic apply_config(input logic [RANK_W-1:0] rank, input logic [ROWCNT_W-1:0] u_rows,
                              input logic [ROWCNT_W-1:0] v_rows, input bit with_spare);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_RANK;
    cfg_data <= {3'b000, rank};
    @(negedge clk);
    cfg_index <= CFG_U_ROWS;
    cfg_data <= u_rows;
    @(negedge clk);
    cfg_index <= CFG_V_ROWS;
    cfg_data <= v_rows;
    if (with_spare) begin
      @(negedge clk);
      cfg_index <= CFG_SPARE;
      cfg_data <= 9'($urandom_range(0, 511));
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random traffic: row loads followed by queries on loaded rows, plus noise.
  task automatic run_phase(input int quota);
    int               sent;
    int               pick;
    int               tries;
    int               n_cols;
    int               style;
    int               lim;
    int               pool;
    bit               found;
    logic [ROW_W-1:0] ur;
    logic [ROW_W-1:0] vr;
    logic [ROW_W-1:0] row;
    opcode_t          side;
    op_item_t         t;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(0, 99);
      found = 1'b0;
      if (pick >= 30 && pick < 80) begin
        for (tries = 0; tries < 24 && !found; tries++) begin
          if ($urandom_range(0, 7) == 0) begin
            ur = ROW_W'($urandom_range(0, 255));
            vr = ROW_W'($urandom_range(0, 255));
          end else begin
            ur = ROW_W'($urandom_range(0, 15));
            vr = ROW_W'($urandom_range(0, 15));
          end
          found = query_ok(ur, vr);
        end
        if (found) begin
          drive_txn(query_item(ur, vr));
          sent++;
        end
      end else if (pick >= 80 && pick < 92) begin
        side = $urandom_range(0, 1) ? OP_LOAD_V : OP_LOAD_U;
        drive_txn(load_item(side, ROW_W'($urandom_range(0, 255)),
                            COL_W'($urandom_range(0, 31)), rand_q16(2)));
        sent++;
      end else if (pick >= 92) begin
        // Unused opcode with random fields; the block ignores it.
        t = load_item(OP_NONE, ROW_W'($urandom_range(0, 255)),
                      COL_W'($urandom_range(0, 31)), $urandom);
        t.qu = ROW_W'($urandom_range(0, 255));
        t.qv = ROW_W'($urandom_range(0, 255));
        drive_txn(t);
      end
      if (pick < 30 || (pick < 80 && !found)) begin
        // Load the leading columns of one row so that later queries can use it.
        side = $urandom_range(0, 1) ? OP_LOAD_V : OP_LOAD_U;
        lim = (side == OP_LOAD_U) ? row_limit(u_rows_cfg) : row_limit(v_rows_cfg);
        pool = (lim == 0 || lim > 16) ? 16 : lim;
        row = ($urandom_range(0, 7) == 0) ? ROW_W'($urandom_range(0, 255))
                                          : ROW_W'($urandom_range(0, pool - 1));
        n_cols = rank_limit();
        if (n_cols == 0)
          n_cols = $urandom_range(1, 4);
        style = $urandom_range(0, 6);
        for (int c = 0; c < n_cols; c++)
          drive_txn(load_item(side, row, c[COL_W-1:0], rand_q16(style)));
        sent += n_cols;
      end
    end
  endtask

  // Receiver stalls in bursts, each followed by a gap with out_stall low.
  initial begin
    forever begin
      @(negedge clk);
      if (!rst && idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Prediction and checking on every accepted transaction.
  always @(posedge clk) begin
    dot_result_t want;
    if (rst) begin
      rank_cfg = 6'd32;
      u_rows_cfg = 9'd256;
      v_rows_cfg = 9'd256;
    end else begin
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_RANK:   rank_cfg = cfg_data[RANK_W-1:0];
          CFG_U_ROWS: u_rows_cfg = cfg_data;
          CFG_V_ROWS: v_rows_cfg = cfg_data;
          default:    ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_dots.size() == 0) begin
          $error("unexpected result: dot_product %h index_error %b saturated %b",
                 dot_product, index_error, saturated);
          mismatches++;
        end else begin
          want = pending_dots.pop_front();
          if (dot_product !== want.dot) begin
            $error("dot_product: expected %h, got %h", want.dot, dot_product);
            mismatches++;
          end
          if (index_error !== want.err) begin
            $error("index_error: expected %b, got %b", want.err, index_error);
            mismatches++;
          end
          if (saturated !== want.sat) begin
            $error("saturated: expected %b, got %b", want.sat, saturated);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (opcode_t'(opcode))
          OP_LOAD_U: u_image[{load_row, load_col}] = load_value;
          OP_LOAD_V: v_image[{load_row, load_col}] = load_value;
          OP_QUERY:  pending_dots.push_back(item_known ? item_known_res :
                                            predict_entry(query_u_row, query_v_row));
          default:   ;
        endcase
      end
    end
  end

  // Watchdog: too long without any transaction on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, random phases, final drain.
  initial begin
    op_item_t directed [$];
    for (int r = 0; r < MAX_ROWS; r++) begin
      u_filled[r] = '0;
      v_filled[r] = '0;
    end
    for (int i = 0; i < STORE_DEPTH; i++) begin
      u_image[i] = '0;
      v_image[i] = '0;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows: rank 2, two U rows and three V rows in range.
    directed.push_back(load_item(OP_LOAD_U, 0, 0, VAL_MAX));
    directed.push_back(load_item(OP_LOAD_U, 0, 1, VAL_MAX));
    directed.push_back(load_item(OP_LOAD_V, 0, 0, VAL_MAX));
    directed.push_back(load_item(OP_LOAD_V, 0, 1, VAL_MAX));
    directed.push_back(known_query(0, 0, 64'sh7FFF_FFFE_0000_0002, 1'b0, 1'b0));
    directed.push_back(load_item(OP_LOAD_U, 1, 0, VAL_MIN));
    directed.push_back(load_item(OP_LOAD_U, 1, 1, VAL_MIN));
    directed.push_back(load_item(OP_LOAD_V, 1, 0, VAL_MIN));
    directed.push_back(load_item(OP_LOAD_V, 1, 1, VAL_MIN));
    // Two most negative squares overflow on the second step.
    directed.push_back(known_query(1, 1, SUM_MAX, 1'b0, 1'b1));
    directed.push_back(query_item(1, 0));
    directed.push_back(query_item(0, 1));
    // Rows at or beyond their row counts.
    directed.push_back(known_query(2, 0, '0, 1'b1, 1'b0));
    directed.push_back(known_query(0, 3, '0, 1'b1, 1'b0));
    directed.push_back(known_query(255, 255, '0, 1'b1, 1'b0));
    directed.push_back(load_item(OP_NONE, 8'hA5, 5'h1A, 32'h1234_5678));
    directed.push_back(load_item(OP_LOAD_U, 0, 1, '0));
    directed.push_back(query_item(0, 0));
    directed.push_back(load_item(OP_LOAD_V, 2, 0, 32'sh0001_0000));
    directed.push_back(load_item(OP_LOAD_V, 2, 1, 32'shFFFF_0000));
    directed.push_back(query_item(0, 2));
    directed.push_back(load_item(OP_LOAD_U, 255, 31, 32'h5555_AAAA));
    directed.push_back(load_item(OP_LOAD_V, 255, 31, 32'hAAAA_5555));

    apply_config(6'd2, 9'd2, 9'd3, 1'b1);
    foreach (directed[i])
      drive_txn(directed[i]);
    drain_results();

    // Each phase ends with the sender paused until every result is in.
    for (int p = 0; p < PHASES; p++) begin
      idle_on = (p != PHASES - 1);
      apply_config(phase_rank[p][RANK_W-1:0], phase_u[p][ROWCNT_W-1:0],
                   phase_v[p][ROWCNT_W-1:0], 1'b0);
      run_phase(phase_items[p]);
      drain_results();
    end

    if (pending_dots.size() != 0) begin
      $error("%0d results never arrived", pending_dots.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
